>>> rtl/core/wmtf_pkg.sv
// Shared types and constants of the weighted move-to-front stack.
`default_nettype none

package wmtf_pkg;

    localparam int ID_W     = 6;
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 22;
    localparam int TOTAL_W  = 48;

    localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ACCESS = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ID_W-1:0]     entry_id;
        logic [WEIGHT_W-1:0] entry_weight;
    } in_word_t;

    typedef struct packed {
        logic [COST_W-1:0]  access_cost;
        logic               found;
        logic [TOTAL_W-1:0] running_total;
    } out_word_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
    } entry_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic search_step;
        logic shift_start;
        logic shift_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic at_end;
        logic match;
        logic at_pos;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/wmtf_ctrl.sv
// Sequencer of the weighted move-to-front stack: search, shift and result phases.
`default_nettype none

module wmtf_ctrl
    import wmtf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] kind,
    output logic            s_ready,
    input  wire sts_t       sts,
    output cmd_t            cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (kind)
                        KIND_LOAD: begin
                            cmd.load = 1'b1;
                        end
                        KIND_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        KIND_ACCESS: begin
                            cmd.start  = 1'b1;
                            state_next = ST_SEARCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (sts.at_end) begin
                    state_next = ST_RESULT;
                end else if (sts.match) begin
                    cmd.shift_start = 1'b1;
                    state_next      = ST_SHIFT;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (sts.at_pos) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // A result word must never overwrite one that has not been taken.
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register busy");

endmodule

`default_nettype wire

>>> rtl/core/wmtf_dpath.sv
// Datapath of the weighted move-to-front stack: entry memory, walk counters, cost and total.
`default_nettype none

module wmtf_dpath
    import wmtf_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_word_t  in_word,
    input  wire cmd_t      cmd,
    output sts_t           sts,
    output out_word_t      out_word,
    output logic           out_valid,
    input  wire logic      out_ready
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    entry_t mem [STACK_DEPTH];
    entry_t rdata_reg;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       idx_reg;
    logic [AW-1:0]       pos_reg;
    logic                hit_reg;
    logic [ID_W-1:0]     id_reg;
    logic [COST_W-1:0]   cost_reg;
    entry_t              carry_reg;
    logic [TOTAL_W-1:0]  total_reg;
    out_word_t           out_reg;
    logic                out_valid_reg;

    logic [CW-1:0]       idx_plus;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    entry_t              mem_wdata;
    logic [COST_W:0]     cost_sum;
    logic [COST_W-1:0]   cost_next;
    logic [TOTAL_W:0]    total_sum;
    logic [TOTAL_W-1:0]  total_next;

    assign idx_plus = idx_reg + CW'(1);

    // The read issued in one cycle is compared or moved in the next.
    always_comb begin
        if (cmd.start || cmd.shift_start) begin
            mem_raddr = '0;
        end else if (cmd.search_step || cmd.shift_step) begin
            mem_raddr = idx_plus[AW-1:0];
        end else begin
            mem_raddr = idx_reg[AW-1:0];
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = carry_reg;
        if (cmd.load && (count_reg < DEPTH_C)) begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[AW-1:0];
            mem_wdata = '{id: in_word.entry_id, weight: in_word.entry_weight};
        end else if (cmd.shift_step) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign cost_sum  = {1'b0, cost_reg} + (COST_W + 1)'(rdata_reg.weight);
    assign cost_next = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
    assign total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(cost_reg);
    assign total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            id_reg   <= in_word.entry_id;
            idx_reg  <= '0;
            cost_reg <= '0;
            hit_reg  <= 1'b0;
        end else if (cmd.search_step) begin
            idx_reg  <= idx_plus;
            cost_reg <= cost_next;
        end else if (cmd.shift_start) begin
            hit_reg   <= 1'b1;
            pos_reg   <= idx_reg[AW-1:0];
            carry_reg <= rdata_reg;
            idx_reg   <= '0;
        end else if (cmd.shift_step) begin
            carry_reg <= rdata_reg;
            idx_reg   <= idx_plus;
        end
        if (cmd.out_load) begin
            out_reg <= '{access_cost: cost_reg, found: hit_reg, running_total: total_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
                total_reg <= '0;
            end else if (cmd.load && (count_reg < DEPTH_C)) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.out_load) begin
                total_reg <= total_next;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts = '{
        at_end:   (idx_reg >= count_reg),
        match:    (rdata_reg.id == id_reg),
        at_pos:   (idx_reg[AW-1:0] == pos_reg),
        out_free: (!out_valid_reg || out_ready)
    };

    assign out_word  = out_reg;
    assign out_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count beyond stack depth");

    // The shift pass only runs after a match and never walks past the match.
    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_step |-> hit_reg && (idx_reg[AW-1:0] <= pos_reg))
        else $error("shift step outside matched range");

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !cmd.clear |=> total_reg >= $past(total_reg))
        else $error("running total decreased without clear");

endmodule

`default_nettype wire

>>> rtl/core/weighted_move_to_front_stack.sv
// Load and clear are done in idle; the next word is accepted in the following cycle.
// Access: a search walk from the top that sums the weights above the match, then on a
// match a shift pass that moves the matched entry to the top; a miss walks all n entries.
// Walks go one entry a cycle; each shift cycle reads one entry and writes the one above it.
// After an access the next word can be taken in the cycle after the result loads, later if held.
// aresetn (synchronous, active low) empties the stack and zeroes the total, not the memory.
`default_nettype none

module weighted_move_to_front_stack
    import wmtf_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    cmd_t cmd;
    sts_t sts;

    wmtf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .kind    (s_data.kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wmtf_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_word   (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_word  (m_data),
        .out_valid (m_valid),
        .out_ready (m_ready)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench of the weighted move-to-front stack.
module tb_top
    import wmtf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int RANDOM_WORDS = 1500;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 40;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum int {WT_RANDOM, WT_MAX, WT_ZERO, WT_EXTREMES} weight_mix_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // Shadow copy of the stack, position 0 is the top.
    logic [ID_W-1:0]     shadow_ids [DEPTH];
    logic [WEIGHT_W-1:0] shadow_weights [DEPTH];
    int                  shadow_count = 0;
    logic [TOTAL_W-1:0]  shadow_total = '0;

    out_word_t pending_results[$];
    int        error_count = 0;
    int        words_applied = 0;
    bit        send_idle = 1'b1;
    bit        recv_idle = 1'b1;
    int        recv_stall = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    weighted_move_to_front_stack #(.STACK_DEPTH(DEPTH)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    task automatic report_mismatch(input string msg);
        if (error_count < 50) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    // Applies one accepted word to the shadow stack; returns 1 when the word
    // produces a result, which is then left in res.
    function automatic bit step_shadow_stack(input in_word_t w, output out_word_t res);
        int                  pos;
        int                  cost;
        logic [ID_W-1:0]     hit_id;
        logic [WEIGHT_W-1:0] hit_wt;
        logic [TOTAL_W:0]    sum;
        res = '0;
        pos = -1;
        cost = 0;
        case (w.kind)
            KIND_LOAD: begin
                if (shadow_count < DEPTH) begin
                    shadow_ids[shadow_count] = w.entry_id;
                    shadow_weights[shadow_count] = w.entry_weight;
                    shadow_count++;
                    words_applied++;
                end
                return 1'b0;
            end
            KIND_CLEAR: begin
                shadow_count = 0;
                shadow_total = '0;
                words_applied++;
                return 1'b0;
            end
            KIND_ACCESS: begin
                for (int k = 0; k < shadow_count && pos < 0; k++) begin
                    if (shadow_ids[k] == w.entry_id) pos = k;
                    else cost += int'(shadow_weights[k]);
                end
                if (cost > int'(COST_MAX)) cost = int'(COST_MAX);
                if (pos >= 0) begin
                    hit_id = shadow_ids[pos];
                    hit_wt = shadow_weights[pos];
                    for (int k = pos; k > 0; k--) begin
                        shadow_ids[k] = shadow_ids[k-1];
                        shadow_weights[k] = shadow_weights[k-1];
                    end
                    shadow_ids[0] = hit_id;
                    shadow_weights[0] = hit_wt;
                end
                sum = {1'b0, shadow_total} + (TOTAL_W + 1)'(cost);
                shadow_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
                res.access_cost = cost[COST_W-1:0];
                res.found = (pos >= 0);
                res.running_total = shadow_total;
                words_applied++;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight(input weight_mix_t mix);
        case (mix)
            WT_MAX:      return '1;
            WT_ZERO:     return '0;
            WT_EXTREMES: return $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 15));
            default:     return 16'($urandom);
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(input logic [1:0] kind, input logic [ID_W-1:0] id,
                             input logic [WEIGHT_W-1:0] wt);
        int        gap;
        in_word_t  w;
        out_word_t res;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        w.kind = kind;
        w.entry_id = id;
        w.entry_weight = wt;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (step_shadow_stack(w, res)) pending_results.insert(pending_results.size(), res);
    endtask

    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word %h with no access waiting", m_data));
            end else begin
                want = pending_results.pop_front();
                if (m_data.access_cost !== want.access_cost)
                    report_mismatch($sformatf("access_cost %0d, expected %0d",
                                              m_data.access_cost, want.access_cost));
                if (m_data.found !== want.found)
                    report_mismatch($sformatf("found %b, expected %b",
                                              m_data.found, want.found));
                if (m_data.running_total !== want.running_total)
                    report_mismatch($sformatf("running_total %0d, expected %0d",
                                              m_data.running_total, want.running_total));
            end
            recv_stall = recv_idle ? $urandom_range(0, 7) : 0;
        end else if (m_valid === 1'b1 && recv_stall > 0) begin
            recv_stall--;
        end
        m_ready <= (recv_stall == 0);
    end

    task automatic test_empty_stack();
        send_word(KIND_ACCESS, 6'd63, 16'hFFFF);
        send_word(KIND_UNUSED, 6'd0, 16'h0000);
        send_word(KIND_CLEAR, 6'd21, 16'h5555);
        send_word(KIND_ACCESS, 6'd0, 16'h0000);
    endtask

    // Top to bottom after loading: 5, 9, 5, 63, 0. The second 5 is hidden
    // behind the first one, and 42 is never loaded.
    task automatic test_load_and_access();
        send_word(KIND_LOAD, 6'd5, 16'hFFFF);
        send_word(KIND_LOAD, 6'd9, 16'h0001);
        send_word(KIND_LOAD, 6'd5, 16'h0000);
        send_word(KIND_LOAD, 6'd63, 16'h8000);
        send_word(KIND_LOAD, 6'd0, 16'h7FFF);
        send_word(KIND_ACCESS, 6'd5, 16'h1234);
        send_word(KIND_ACCESS, 6'd63, 16'h0000);
        send_word(KIND_ACCESS, 6'd5, 16'hFFFF);
        send_word(KIND_ACCESS, 6'd42, 16'h0000);
        send_word(KIND_ACCESS, 6'd0, 16'hAAAA);
        send_word(KIND_ACCESS, 6'd9, 16'h0000);
    endtask

    task automatic test_clear();
        send_word(KIND_CLEAR, 6'd63, 16'hFFFF);
        send_word(KIND_ACCESS, 6'd9, 16'h0000);
        send_word(KIND_LOAD, 6'd9, 16'h00FF);
        send_word(KIND_ACCESS, 6'd9, 16'h0000);
    endtask

    // Each session clears, loads a stack of random size (often full, with
    // loads past the top), then mostly accesses entries that are present.
    task automatic test_random_sessions();
        int              target;
        int              fill;
        int              id_span;
        int              roll;
        weight_mix_t     mix;
        logic [ID_W-1:0] id;
        target = words_applied + RANDOM_WORDS;
        while (words_applied < target) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            mix = weight_mix_t'($urandom_range(0, 3));
            id_span = $urandom_range(0, 1) ? 63 : 7;
            roll = $urandom_range(0, 9);
            if (roll < 3) fill = DEPTH + $urandom_range(0, 3);
            else fill = $urandom_range(0, (roll < 7) ? 12 : DEPTH);
            send_word(KIND_CLEAR, 6'($urandom), 16'($urandom));
            repeat (fill) send_word(KIND_LOAD, 6'($urandom_range(0, id_span)), pick_weight(mix));
            repeat ($urandom_range(4, 30)) begin
                roll = $urandom_range(0, 99);
                if (roll < 80 && shadow_count > 0)
                    id = shadow_ids[$urandom_range(0, shadow_count - 1)];
                else
                    id = 6'($urandom);
                if (roll >= 94) send_word(KIND_UNUSED, 6'($urandom), 16'($urandom));
                else if (roll >= 88) send_word(KIND_LOAD, 6'($urandom), pick_weight(mix));
                else send_word(KIND_ACCESS, id, 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_stack();
        test_load_and_access();
        test_clear();
        test_random_sessions();
        s_valid <= 1'b0;
        for (int n = 0; n < 20000 && pending_results.size() != 0; n++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d access results never arrived",
                                      pending_results.size()));
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TIMEOUT with %0d access results outstanding", pending_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/wmtf_pkg.sv
rtl/core/wmtf_ctrl.sv
rtl/core/wmtf_dpath.sv
rtl/core/weighted_move_to_front_stack.sv
tb/tb_top.sv
